>>> rtl/asd_pkg.sv
// asd_pkg: shared types, widths and constants of the accelerometer step detector
// depends on nothing; imported by every module of the block

package asd_pkg;

	// axis sample width, range 8 to 24
	localparam int ACCEL_BITS = 16;

	// sum of three squares, its root, the filter word and the filter accumulator
	localparam int SQ_W       = 2 * ACCEL_BITS + 2;
	localparam int MAG_W      = SQ_W / 2;
	localparam int ROOT_STEPS = SQ_W / 2;
	localparam int ROOT_CNT_W = $clog2(ROOT_STEPS);
	localparam int FILT_W     = 24;
	localparam int FRAC_W     = 8;
	localparam int PA_W       = MAG_W + FRAC_W + 7;
	localparam int PB_W       = FILT_W + 8;
	localparam int ACC_W      = ((PA_W > PB_W) ? PA_W : PB_W) + 1;

	// filter coefficients, alpha = 77/256
	localparam logic [7:0] ALPHA_NUM  = 8'd77;
	localparam logic [7:0] ALPHA_REST = 8'd179;
	localparam logic [7:0] ROUND_HALF = 8'd128;

	// configuration register indexes
	localparam logic [7:0] CFG_THRESHOLD = 8'd0;
	localparam logic [7:0] CFG_INTERVAL  = 8'd1;

	localparam logic [15:0] THRESHOLD_RESET = 16'd9830;
	localparam logic [15:0] INTERVAL_RESET  = 16'd300;

	// path codes of a result
	localparam logic [1:0] PATH_NONE     = 2'd0;
	localparam logic [1:0] PATH_HARDWARE = 2'd1;
	localparam logic [1:0] PATH_SOFTWARE = 2'd2;

	typedef struct packed {
		logic        [31:0]           hardware_count;
		logic signed [ACCEL_BITS-1:0] accel_x;
		logic signed [ACCEL_BITS-1:0] accel_y;
		logic signed [ACCEL_BITS-1:0] accel_z;
		logic        [31:0]           now_ms;
	} sample_t;

	typedef struct packed {
		logic [31:0]       total_steps;
		logic [31:0]       steps_added;
		logic [1:0]        path_taken;
		logic [FILT_W-1:0] smoothed_magnitude;
	} result_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic square;
		logic sum;
		logic root;
		logic filt;
		logic commit;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic hw_rise;
	} dp_status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SQUARE,
		ST_SUM,
		ST_ROOT,
		ST_FILT,
		ST_COMMIT
	} ctrl_state_t;

endpackage

>>> rtl/asd_datapath.sv
// asd_datapath: squares, iterative square root, low-pass filter, step decision,
// configuration and step state, result register; uses asd_pkg

module asd_datapath (
	input  logic                clk,
	input  logic                arst_n,
	input  asd_pkg::dp_cmd_t    cmd,
	output asd_pkg::dp_status_t status,
	input  asd_pkg::sample_t    sample,
	input  logic                cfg_we,
	input  logic [7:0]          cfg_index,
	input  logic [15:0]         cfg_data,
	output asd_pkg::result_t    result
);
	import asd_pkg::*;

	logic [15:0] thr_q;
	logic [15:0] min_int_q;

	logic [31:0]       step_total_q;
	logic [31:0]       last_hw_q;
	logic [FILT_W-1:0] filt_q;
	logic [FILT_W-1:0] prev_q;
	logic [31:0]       last_step_q;

	sample_t sample_q;
	logic    hw_rise_q;

	logic signed [2*ACCEL_BITS-1:0] sqx_s1, sqy_s1, sqz_s1;
	logic signed [2*ACCEL_BITS-1:0] ax, ay, az;

	logic [SQ_W-1:0] n_q, res_q, bit_q;
	logic [SQ_W-1:0] trial;

	logic [ACC_W-1:0]       pa_q, pb_q;
	logic [ACC_W-1:0]       acc;
	logic [MAG_W+FRAC_W-1:0] mag_shift;
	logic [ACC_W-9:0]       f_full;
	logic [FILT_W-1:0]      f_sat;
	logic signed [FILT_W+1:0] diff, thr_ext;
	logic [31:0]            elapsed;
	logic                   step_ok;

	result_t result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q     <= THRESHOLD_RESET;
			min_int_q <= INTERVAL_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_THRESHOLD: thr_q     <= cfg_data;
				CFG_INTERVAL:  min_int_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign ax = (2*ACCEL_BITS)'(sample_q.accel_x);
	assign ay = (2*ACCEL_BITS)'(sample_q.accel_y);
	assign az = (2*ACCEL_BITS)'(sample_q.accel_z);

	assign trial     = res_q + bit_q;
	assign mag_shift = {res_q[MAG_W-1:0], {FRAC_W{1'b0}}};

	// filter output, saturated, and the step decision
	always_comb begin
		acc     = pa_q + pb_q + ACC_W'(ROUND_HALF);
		f_full  = acc[ACC_W-1:FRAC_W];
		f_sat   = (|f_full[ACC_W-9:FILT_W]) ? {FILT_W{1'b1}} : f_full[FILT_W-1:0];
		diff    = $signed({2'b00, f_sat}) - $signed({2'b00, prev_q});
		thr_ext = $signed({2'b00, thr_q, {FRAC_W{1'b0}}});
		elapsed = sample_q.now_ms - last_step_q;
		step_ok = (diff > thr_ext) && (elapsed > {16'd0, min_int_q});
	end

	// working registers, no reset needed
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			sample_q  <= sample;
			hw_rise_q <= sample.hardware_count > last_hw_q;
		end
		if (cmd.square) begin
			sqx_s1 <= ax * ax;
			sqy_s1 <= ay * ay;
			sqz_s1 <= az * az;
		end
		if (cmd.sum) begin
			n_q   <= SQ_W'($unsigned(sqx_s1)) + SQ_W'($unsigned(sqy_s1))
			         + SQ_W'($unsigned(sqz_s1));
			res_q <= '0;
			bit_q <= SQ_W'(1) << (SQ_W - 2);
		end
		if (cmd.root) begin
			if (n_q >= trial) begin
				n_q   <= n_q - trial;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
		if (cmd.filt) begin
			pa_q <= ACC_W'(mag_shift) * ACC_W'(ALPHA_NUM);
			pb_q <= ACC_W'(filt_q) * ACC_W'(ALPHA_REST);
		end
	end

	// step state and result beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_total_q <= '0;
			last_hw_q    <= '0;
			filt_q       <= '0;
			prev_q       <= '0;
			last_step_q  <= '0;
		end else if (cmd.commit) begin
			if (hw_rise_q) begin
				step_total_q <= step_total_q + (sample_q.hardware_count - last_hw_q);
				last_hw_q    <= sample_q.hardware_count;
			end else begin
				filt_q <= f_sat;
				prev_q <= f_sat;
				if (step_ok) begin
					step_total_q <= step_total_q + 32'd1;
					last_step_q  <= sample_q.now_ms;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			if (hw_rise_q) begin
				result_q.total_steps <= step_total_q
				                        + (sample_q.hardware_count - last_hw_q);
				result_q.steps_added <= sample_q.hardware_count - last_hw_q;
				result_q.path_taken  <= PATH_HARDWARE;
				result_q.smoothed_magnitude <= filt_q;
			end else begin
				result_q.total_steps <= step_total_q + (step_ok ? 32'd1 : 32'd0);
				result_q.steps_added <= step_ok ? 32'd1 : 32'd0;
				result_q.path_taken  <= step_ok ? PATH_SOFTWARE : PATH_NONE;
				result_q.smoothed_magnitude <= f_sat;
			end
		end
	end

	assign status.hw_rise = hw_rise_q;
	assign result         = result_q;

endmodule

>>> rtl/asd_ctrl.sv
// asd_ctrl: sequencer for one sample and the result valid flag
// depends on asd_pkg; drives the command struct of asd_datapath

module asd_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                sample_valid,
	output logic                sample_stall,
	output logic                result_valid,
	input  logic                result_stall,
	input  asd_pkg::dp_status_t status,
	output asd_pkg::dp_cmd_t    cmd
);
	import asd_pkg::*;

	ctrl_state_t           state_q, state_d;
	logic [ROOT_CNT_W-1:0] cnt_q, cnt_d;
	logic                  valid_q, valid_d;
	logic                  out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			valid_q <= valid_d;
		end
	end

	assign out_free = !valid_q || !result_stall;

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		cmd     = '0;
		valid_d = valid_q && result_stall;
		case (state_q)
			ST_IDLE: begin
				if (sample_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_SQUARE;
				end
			end
			ST_SQUARE: begin
				// hardware count rose: skip the software path
				if (status.hw_rise) begin
					state_d = ST_COMMIT;
				end else begin
					cmd.square = 1'b1;
					state_d    = ST_SUM;
				end
			end
			ST_SUM: begin
				cmd.sum = 1'b1;
				cnt_d   = '0;
				state_d = ST_ROOT;
			end
			ST_ROOT: begin
				cmd.root = 1'b1;
				cnt_d    = cnt_q + 1'b1;
				if (cnt_q == ROOT_CNT_W'(ROOT_STEPS - 1)) begin
					state_d = ST_FILT;
				end
			end
			ST_FILT: begin
				cmd.filt = 1'b1;
				state_d  = ST_COMMIT;
			end
			ST_COMMIT: begin
				if (out_free) begin
					cmd.commit = 1'b1;
					valid_d    = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign sample_stall = (state_q != ST_IDLE);
	assign result_valid = valid_q;

endmodule

>>> rtl/accel_step_detector.sv
// accel_step_detector: top level of the accelerometer step detector
// depends on asd_pkg, asd_ctrl and asd_datapath

// One result beat per sample beat. A sample whose hardware count rose above the last
// one taken goes from the square state straight to commit; any other sample runs
// the software path through the square, sum, root and filter states; the square root
// settles two radicand bits per cycle. One sample is in work at a time; the next is
// taken as soon as the previous one has been written to the result register, even
// while that result still waits to be taken.
// Configuration writes are always ready and are meant for idle periods only.

module accel_step_detector (
	input  logic             clk,
	input  logic             arst_n,
	// sample channel
	input  logic             sample_valid,
	output logic             sample_stall,
	input  asd_pkg::sample_t sample,
	// result channel
	output logic             result_valid,
	input  logic             result_stall,
	output asd_pkg::result_t result,
	// configuration writes
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [7:0]       cfg_index,
	input  logic [15:0]      cfg_data
);
	import asd_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t status;

	// registers take a write in any cycle
	assign cfg_ready = 1'b1;

	asd_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.status       (status),
		.cmd          (cmd)
	);

	// squares, root, filter, decision and step state
	asd_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.sample    (sample),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.result    (result)
	);

endmodule

>>> rtl/asd_checker.sv
// asd_checker: port-level assertions for accel_step_detector
// depends on asd_pkg; bound to the top level at the end of this file

module asd_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             sample_valid,
	input logic             sample_stall,
	input logic             result_valid,
	input logic             result_stall,
	input asd_pkg::result_t result
);
	import asd_pkg::*;

	// a held result beat keeps its payload
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("result changed while stalled");

	// one sample in work at a time
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		sample_valid && !sample_stall |=> sample_stall)
		else $error("sample taken while busy");

	// no step path reports nothing added
	a_none: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.path_taken == PATH_NONE |-> result.steps_added == 32'd0)
		else $error("steps added without a step");

	// a software step adds exactly one, and the path code is never unused
	a_soft: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.path_taken == PATH_NONE
		|| result.path_taken == PATH_HARDWARE
		|| (result.path_taken == PATH_SOFTWARE && result.steps_added == 32'd1)))
		else $error("bad path code or software step count");

endmodule

bind accel_step_detector asd_checker u_asd_checker (.*);
